### sv/ssef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssef_pkg;
  localparam int unsigned COORD_BITS_DEF  = 24;
  localparam int unsigned ID_BITS_DEF     = 16;
  localparam int unsigned COUNT_LIMIT_DEF = 1024;
  localparam int unsigned CFG_IDX_BITS    = 3;
  localparam int unsigned CNT_BITS        = 11;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_X   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_Y   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_Z   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX     = 3'd6;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
endpackage
`default_nettype wire

### sv/segment_sphere_entity_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake          Payload
// entity    in   in_valid/in_ready  id, has_origin, origin, box min/max, list_end
// result    out  out_valid/out_ready kind, matched_id, match_count, last
// config    in   cfg_we             cfg_idx, cfg_data
// Six-stage geometry pipeline accepts one entity per cycle while in_ready is high;
// a result passes its 6 pipeline stages, the queue and 1 output register before it is offered.
// A list_end entity that matches gives the back end two results (match then summary).
// Input stalls when queue count plus items in the pipeline reaches 8; output stalls hold.
// Reset clears counts, queue and config (max_matches to 1024).
module segment_sphere_entity_filter #(
  parameter int unsigned COORD_BITS  = ssef_pkg::COORD_BITS_DEF,
  parameter int unsigned ID_BITS     = ssef_pkg::ID_BITS_DEF,
  parameter int unsigned COUNT_LIMIT = ssef_pkg::COUNT_LIMIT_DEF
) (
  input  wire clk_i,
  input  wire rst_ni,
  input  wire cfg_we_i,
  input  wire logic [ssef_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [COORD_BITS-1:0] cfg_data_i,
  input  wire in_valid_i,
  output logic in_ready_o,
  input  wire logic [ID_BITS-1:0] entity_id_i,
  input  wire has_origin_i,
  input  wire logic signed [COORD_BITS-1:0] origin_x_i, origin_y_i, origin_z_i,
  input  wire logic signed [COORD_BITS-1:0] box_min_x_i, box_min_y_i, box_min_z_i,
  input  wire logic signed [COORD_BITS-1:0] box_max_x_i, box_max_y_i, box_max_z_i,
  input  wire list_end_i,
  output logic out_valid_o,
  input  wire out_ready_i,
  output logic kind_o,
  output logic [ID_BITS-1:0] matched_id_o,
  output logic [10:0] match_count_o,
  output logic last_o
);
  import ssef_pkg::*;
  localparam int unsigned DEPTH = 8;
  localparam int unsigned QW = ID_BITS + 2;

  logic signed [COORD_BITS-1:0] st_q [3], en_q [3];
  logic [10:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin st_q[i] <= '0; en_q[i] <= '0; end
      max_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_X: st_q[0] <= cfg_data_i;
        REG_START_Y: st_q[1] <= cfg_data_i;
        REG_START_Z: st_q[2] <= cfg_data_i;
        REG_END_X:   en_q[0] <= cfg_data_i;
        REG_END_Y:   en_q[1] <= cfg_data_i;
        REG_END_Z:   en_q[2] <= cfg_data_i;
        REG_MAX:     max_q <= 11'(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic signed [COORD_BITS-1:0] org [3], mn [3], mx [3];
  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign mn  = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign mx  = '{box_max_x_i, box_max_y_i, box_max_z_i};

  logic g_v, g_hit, g_end, q_empty, q_pop;
  logic [ID_BITS-1:0] g_id;
  logic [QW-1:0] q_rd;
  logic [$clog2(DEPTH+1)-1:0] q_cnt;

  // count of pipeline stages holding items, so the queue never overflows
  logic [5:0] pv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= '0;
    else pv_q <= {pv_q[4:0], in_valid_i && in_ready_o};
  end
  assign in_ready_o = (4'(q_cnt) + 4'($countones(pv_q))) < 4'(DEPTH);

  ssef_geom #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_geom (
    .clk_i, .rst_ni, .en_i(1'b1), .in_valid_i(in_valid_i && in_ready_o),
    .in_id_i(entity_id_i), .in_has_i(has_origin_i), .in_end_i(list_end_i),
    .org_i(org), .mn_i(mn), .mx_i(mx), .st_i(st_q), .en_pt_i(en_q),
    .out_valid_o(g_v), .out_id_o(g_id), .out_hit_o(g_hit), .out_end_o(g_end)
  );

  ssef_fifo #(.W(QW), .DEPTH(DEPTH)) u_fifo (
    .clk_i, .rst_ni, .push_i(g_v), .wdata_i({g_id, g_hit, g_end}),
    .pop_i(q_pop), .rdata_o(q_rd), .empty_o(q_empty), .count_o(q_cnt)
  );

  ssef_back #(.ID_BITS(ID_BITS), .COUNT_LIMIT(COUNT_LIMIT)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_id_i(q_rd[QW-1:2]),
    .q_hit_i(q_rd[1]), .q_end_i(q_rd[0]), .q_pop_o(q_pop), .max_i(max_q),
    .out_valid_o, .out_ready_i, .kind_o, .matched_id_o, .match_count_o, .last_o
  );
endmodule
`default_nettype wire

### sv/ssef_geom.sv
`timescale 1ns / 1ps
`default_nettype none
// Geometry pipeline: squared-distance segment/sphere test, one entity per cycle while en_i is high.
// Stage 1: differences. Stage 2: products. Stage 3: sums/cross/radius. Stage 4: half-width
// partial products of the cross squares and of rad2*len2, range check. Stage 5: squares and the
// product. Stage 6: sum of squares and compare.
module ssef_geom #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned ID_BITS    = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          in_valid_i,
  input  wire logic [ID_BITS-1:0]      in_id_i,
  input  wire                          in_has_i,
  input  wire                          in_end_i,
  input  wire logic signed [COORD_BITS-1:0] org_i [3],
  input  wire logic signed [COORD_BITS-1:0] mn_i  [3],
  input  wire logic signed [COORD_BITS-1:0] mx_i  [3],
  input  wire logic signed [COORD_BITS-1:0] st_i  [3],
  input  wire logic signed [COORD_BITS-1:0] en_pt_i [3],
  output logic                         out_valid_o,
  output logic [ID_BITS-1:0]           out_id_o,
  output logic                         out_hit_o,
  output logic                         out_end_o
);
  localparam int unsigned DB = COORD_BITS + 1;
  localparam int unsigned PB = 2 * DB;
  localparam int unsigned SB = PB + 2;
  localparam int unsigned CB = PB + 1;
  localparam int unsigned HB = SB / 2;
  localparam int unsigned RH = SB - HB;
  localparam int unsigned LB = CB / 2;
  localparam int unsigned UB = CB - LB;
  localparam int unsigned WB = 2 * SB + 2;
  localparam int unsigned NS = 6;

  logic [NS-1:0] v_q;
  logic [ID_BITS-1:0] id_q [NS];
  logic [NS-1:0] has_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      id_q[0] <= in_id_i;
      has_q[0] <= in_has_i;
      end_q[0] <= in_end_i;
      for (int s = 1; s < NS; s++) begin
        id_q[s] <= id_q[s-1];
        has_q[s] <= has_q[s-1];
        end_q[s] <= end_q[s-1];
      end
    end
  end

  // stage 1: differences
  logic signed [DB-1:0] d1_q [3], r1_q [3];
  logic signed [COORD_BITS-1:0] mn1_q [3], mx1_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i]  <= DB'(en_pt_i[i]) - DB'(st_i[i]);
        r1_q[i]  <= DB'(org_i[i]) - DB'(st_i[i]);
        mn1_q[i] <= mn_i[i];
        mx1_q[i] <= mx_i[i];
      end
    end
  end

  // stage 2: products
  logic signed [PB-1:0] dd2_q [3], rd2_q [3], rr2_q [3], a2_q [3], b2_q [3];
  logic signed [PB-1:0] xp2_q [3], xn2_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dd2_q[i] <= d1_q[i] * d1_q[i];
        rd2_q[i] <= r1_q[i] * d1_q[i];
        rr2_q[i] <= r1_q[i] * r1_q[i];
        a2_q[i]  <= PB'(mn1_q[i]) * PB'(mn1_q[i]);
        b2_q[i]  <= PB'(mx1_q[i]) * PB'(mx1_q[i]);
        xp2_q[i] <= r1_q[(i+1)%3] * d1_q[(i+2)%3];
        xn2_q[i] <= r1_q[(i+2)%3] * d1_q[(i+1)%3];
      end
    end
  end

  // stage 3: sums, cross components, radius pick
  logic signed [SB-1:0] len3_q, dot3_q, rr3_q, rad3_q;
  logic signed [CB-1:0] c3_q [3];
  logic signed [SB-1:0] a3, b3;
  always_comb begin
    a3 = SB'(a2_q[0]) + SB'(a2_q[1]) + SB'(a2_q[2]);
    b3 = SB'(b2_q[0]) + SB'(b2_q[1]) + SB'(b2_q[2]);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len3_q <= SB'(dd2_q[0]) + SB'(dd2_q[1]) + SB'(dd2_q[2]);
      dot3_q <= SB'(rd2_q[0]) + SB'(rd2_q[1]) + SB'(rd2_q[2]);
      rr3_q  <= SB'(rr2_q[0]) + SB'(rr2_q[1]) + SB'(rr2_q[2]);
      rad3_q <= (a3 <= b3) ? b3 : a3;
      for (int i = 0; i < 3; i++) c3_q[i] <= CB'(xp2_q[i]) - CB'(xn2_q[i]);
    end
  end

  // stage 4: half-width partial products, range check
  // cross component c = ch * 2^LB + cl, ch signed upper half, cl unsigned lower half
  logic signed [2*UB-1:0] chh4_q [3];
  logic signed [UB+LB:0]  chl4_q [3];
  logic [2*LB-1:0]        cll4_q [3];
  logic [SB-1:0] len4_q, rr4_q, rad4_q;
  logic rng4_q;
  logic [RH-1:0] rh, lh;
  logic [HB-1:0] rl, ll;
  logic signed [UB-1:0] ch [3];
  logic signed [LB:0] cl [3];
  logic [2*RH-1:0] phh4_q;
  logic [SB-1:0] phl4_q, plh4_q;
  logic [2*HB-1:0] pll4_q;
  always_comb begin
    rh = rad3_q[SB-1:HB]; rl = rad3_q[HB-1:0];
    lh = len3_q[SB-1:HB]; ll = len3_q[HB-1:0];
    for (int i = 0; i < 3; i++) begin
      ch[i] = c3_q[i][CB-1:LB];
      cl[i] = {1'b0, c3_q[i][LB-1:0]};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        chh4_q[i] <= ch[i] * ch[i];
        chl4_q[i] <= ch[i] * cl[i];
        cll4_q[i] <= c3_q[i][LB-1:0] * c3_q[i][LB-1:0];
      end
      len4_q <= len3_q;
      rr4_q  <= rr3_q;
      rad4_q <= rad3_q;
      rng4_q <= (dot3_q >= 0) && (dot3_q <= len3_q);
      phh4_q <= rh * lh;
      phl4_q <= rh * ll;
      plh4_q <= rl * lh;
      pll4_q <= rl * ll;
    end
  end

  // stage 5: cross squares and the product
  logic [WB-1:0] cs5_q [3], prod5_q;
  logic zero5_q, dist5_q, rng5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++)
        cs5_q[i] <= (WB'(chh4_q[i]) << (2*LB)) + (WB'(chl4_q[i]) << (LB+1)) +
                    WB'(cll4_q[i]);
      prod5_q <= (WB'(phh4_q) << (2*HB)) + ((WB'(phl4_q) + WB'(plh4_q)) << HB) + WB'(pll4_q);
      zero5_q <= (len4_q == '0);
      dist5_q <= (rr4_q <= rad4_q);
      rng5_q  <= rng4_q;
    end
  end

  // stage 6: sum of cross squares and final compare
  logic [WB-1:0] cr6;
  logic hit6_q;
  always_comb begin
    cr6 = cs5_q[0] + cs5_q[1] + cs5_q[2];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) hit6_q <= zero5_q ? dist5_q : (rng5_q && (cr6 <= prod5_q));
  end

  assign out_valid_o = v_q[NS-1];
  assign out_id_o    = id_q[NS-1];
  assign out_hit_o   = hit6_q && has_q[NS-1];
  assign out_end_o   = end_q[NS-1];
endmodule
`default_nettype wire

### sv/ssef_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Short queue between the geometry front and the counting back.
module ssef_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire              pop_i,
  output logic [W-1:0]     rdata_o,
  output logic             empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int unsigned AB = $clog2(DEPTH);
  logic [W-1:0] mem_q [DEPTH];
  logic [AB-1:0] wp_q, rp_q;
  logic [$clog2(DEPTH+1)-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AB'(DEPTH-1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AB'(DEPTH-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + {{($bits(cnt_q)-1){1'b0}}, push_i} - {{($bits(cnt_q)-1){1'b0}}, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == DEPTH |-> !push_i || pop_i) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif
endmodule
`default_nettype wire

### sv/ssef_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: match counting against the limit and result emission.
module ssef_back #(
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned COUNT_LIMIT = 1024
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     q_empty_i,
  input  wire logic [ID_BITS-1:0] q_id_i,
  input  wire                     q_hit_i,
  input  wire                     q_end_i,
  output logic                    q_pop_o,
  input  wire logic [10:0]        max_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic                    kind_o,
  output logic [ID_BITS-1:0]      matched_id_o,
  output logic [10:0]             match_count_o,
  output logic                    last_o
);
  import ssef_pkg::*;
  localparam logic [10:0] LIM = 11'(COUNT_LIMIT > 2047 ? 2047 : COUNT_LIMIT);

  logic [10:0] cnt_q, cnt_d, lim;
  logic sum_q, sum_d; // match phase of an end item done, summary pending
  logic ov_q, ov_d;
  logic kind_q, kind_d, last_q, last_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic [10:0] mc_q, mc_d;
  logic take_m, free;

  assign lim   = (max_i > LIM) ? LIM : max_i;
  assign free  = !ov_q || out_ready_i;
  assign take_m = q_hit_i && (cnt_q < lim);

  always_comb begin
    cnt_d = cnt_q; sum_d = sum_q; ov_d = ov_q && !out_ready_i;
    kind_d = kind_q; last_d = last_q; id_d = id_q; mc_d = mc_q;
    q_pop_o = 1'b0;
    if (free && !q_empty_i) begin
      if (sum_q) begin
        ov_d = 1'b1; kind_d = KIND_SUMMARY; id_d = '0; mc_d = cnt_q; last_d = 1'b1;
        cnt_d = '0; sum_d = 1'b0; q_pop_o = 1'b1;
      end else if (take_m) begin
        ov_d = 1'b1; kind_d = KIND_MATCH; id_d = q_id_i; mc_d = cnt_q + 1'b1;
        last_d = !q_end_i; cnt_d = cnt_q + 1'b1;
        if (q_end_i) sum_d = 1'b1; else q_pop_o = 1'b1;
      end else if (q_end_i) begin
        ov_d = 1'b1; kind_d = KIND_SUMMARY; id_d = '0; mc_d = cnt_q; last_d = 1'b1;
        cnt_d = '0; q_pop_o = 1'b1;
      end else begin
        q_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sum_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; sum_q <= sum_d; ov_q <= ov_d;
    end
  end
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; last_q <= last_d; id_q <= id_d; mc_q <= mc_d;
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = kind_q;
  assign matched_id_o  = id_q;
  assign match_count_o = mc_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_cnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LIM) else $error("count above limit");
  a_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_ready_i && kind_q == KIND_SUMMARY |-> matched_id_o == '0)
    else $error("summary carries id");
  a_match_notlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q |-> ov_q && kind_q == KIND_MATCH && !last_q || $past(sum_q))
    else $error("pending summary without match");
`endif
endmodule
`default_nettype wire
